@@ src/wes_pkg.sv @@
// Shared constants, types and a helper function for the windowed event statistics core.
// Every other file of the block depends on this package.
package wes_pkg;

   localparam int DEPTH     = 64;
   localparam int SLOT_W    = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int OP_W      = 2;
   localparam int TIME_W    = 48;
   localparam int DIST_W    = 24;
   localparam int WINDOW_W  = 27;
   localparam int SPAN_W    = 37;
   localparam int TOTAL_W   = 32;
   localparam int OUT_CNT_W = 7;
   localparam int SUM_W     = DIST_W + CNT_W;
   localparam int STEP_W    = $clog2(SUM_W + 1);

   localparam logic [SPAN_W-1:0]   US_PER_MS    = SPAN_W'(1000);
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60000);

   typedef enum logic [OP_W-1:0] {
      OP_RECORD  = 2'd0,
      OP_QUERY   = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef struct packed {
      logic capture;
      logic calc_span;
      logic calc_start;
      logic scan_step;
      logic div_init;
      logic div_step;
      logic load_result;
   } wes_cmd_type;

   typedef struct packed {
      logic is_query;
      logic scan_done;
      logic div_done;
   } wes_status_type;

   function automatic logic [OUT_CNT_W-1:0] fit_count(input logic [CNT_W-1:0] value);
      logic [31:0] wide;
      wide = 32'(value);
      return wide[OUT_CNT_W-1:0];
   endfunction

endpackage

@@ src/wes_channels.sv @@
// Request and response channel interfaces with valid/ready handshakes.
// Depends on wes_pkg for the field widths.
interface wes_req_if;
   import wes_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [TIME_W-1:0]   now_us;
   logic [DIST_W-1:0]   distance;
   modport source (output valid, operation, now_us, distance, input ready);
   modport sink (input valid, operation, now_us, distance, output ready);
endinterface

interface wes_rsp_if;
   import wes_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUT_CNT_W-1:0] window_count;
   logic [DIST_W-1:0]    average_distance;
   logic [TOTAL_W-1:0]   total_count;
   logic [OUT_CNT_W-1:0] stored_count;
   logic [TIME_W-1:0]    interval_us;
   logic                 timer_running;
   modport source (output valid, window_count, average_distance, total_count, stored_count,
                   interval_us, timer_running, input ready);
   modport sink (input valid, window_count, average_distance, total_count, stored_count,
                 interval_us, timer_running, output ready);
endinterface

@@ src/windowed_event_statistics_core.sv @@
// Windowed event statistics core: record, query and timer-restart items, one result each.
// Record, restart and unknown items pass the span and finish states; finish waits for a free output register.
// A query passes through the span, start, scan, divide-init, divide and finish states
// over a ring of 64 entries: one ring read per stored entry, then one quotient bit per cycle.
// One item is in flight at a time; the next can be accepted in the cycle after the result is loaded.
// Synchronous reset clears stored and total counts, timer state and window setting, but not the ring memory.
module windowed_event_statistics_core (
   input  logic                          clock,
   input  logic                          reset,
   wes_req_if.sink                       req_chan,
   wes_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [wes_pkg::WINDOW_W-1:0]  csr_write_data
);
   import wes_pkg::*;

   wes_cmd_type    cmd;
   wes_status_type status;

   wes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   wes_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_operation        (req_chan.operation),
      .req_now_us           (req_chan.now_us),
      .req_distance         (req_chan.distance),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .rsp_window_count     (rsp_chan.window_count),
      .rsp_average_distance (rsp_chan.average_distance),
      .rsp_total_count      (rsp_chan.total_count),
      .rsp_stored_count     (rsp_chan.stored_count),
      .rsp_interval_us      (rsp_chan.interval_us),
      .rsp_timer_running    (rsp_chan.timer_running)
   );

endmodule

@@ src/wes_ctrl.sv @@
// Sequencing state machine for the statistics core: handshakes, scan and divide phases.
// Depends on wes_pkg for the command and status structs.
module wes_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output wes_pkg::wes_cmd_type    cmd,
   input  wes_pkg::wes_status_type status
);
   import wes_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SPAN,
      S_START,
      S_SCAN,
      S_DIV_INIT,
      S_DIV,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SPAN;
            end
         end
         S_SPAN: begin
            cmd.calc_span = 1'b1;
            state_in      = status.is_query ? S_START : S_FINISH;
         end
         S_START: begin
            cmd.calc_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_DIV_INIT;
            end
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.load_result = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/wes_datapath.sv @@
// Datapath of the statistics core: event ring memory, counters, window scan and divider.
// Depends on wes_pkg; driven by commands from wes_ctrl.
module wes_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  wes_pkg::wes_cmd_type             cmd,
   output wes_pkg::wes_status_type          status,
   input  logic [wes_pkg::OP_W-1:0]         req_operation,
   input  logic [wes_pkg::TIME_W-1:0]       req_now_us,
   input  logic [wes_pkg::DIST_W-1:0]       req_distance,
   input  logic                             csr_write_enable,
   input  logic [wes_pkg::WINDOW_W-1:0]     csr_write_data,
   output logic [wes_pkg::OUT_CNT_W-1:0]    rsp_window_count,
   output logic [wes_pkg::DIST_W-1:0]       rsp_average_distance,
   output logic [wes_pkg::TOTAL_W-1:0]      rsp_total_count,
   output logic [wes_pkg::OUT_CNT_W-1:0]    rsp_stored_count,
   output logic [wes_pkg::TIME_W-1:0]       rsp_interval_us,
   output logic                             rsp_timer_running
);
   import wes_pkg::*;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [DIST_W-1:0] distance;
   } entry_type;

   entry_type            ring_mem [DEPTH];
   entry_type            rd_ff;
   logic                 rd_valid_ff;

   logic [WINDOW_W-1:0]  window_ff;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     stored_ff;
   logic [TOTAL_W-1:0]   total_ff;
   logic [TIME_W-1:0]    start_time_ff;
   logic [TIME_W-1:0]    last_ff;
   logic                 running_ff;

   logic                 query_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [SPAN_W-1:0]    span_ff;
   logic [TIME_W-1:0]    lower_ff, lower_in;

   logic [CNT_W-1:0]     idx_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [SUM_W-1:0]     acc_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [STEP_W-1:0]    steps_ff;
   logic                 issue;
   logic                 hit;
   logic [CNT_W:0]       shifted;
   logic [CNT_W:0]       diff;

   assign slot_in  = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign lower_in = (TIME_W'(span_ff) > now_ff) ? '0 : now_ff - TIME_W'(span_ff);
   assign issue    = cmd.scan_step && (idx_ff < stored_ff);
   assign hit      = (rd_ff.stamp >= lower_ff) && (rd_ff.stamp <= now_ff);
   assign shifted  = {rem_ff, acc_ff[SUM_W-1]};
   assign diff     = shifted - {1'b0, count_ff};

   assign status.is_query  = query_ff;
   assign status.scan_done = (idx_ff == stored_ff) && !rd_valid_ff;
   assign status.div_done  = (steps_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.capture && (req_operation == OP_RECORD)) begin
         ring_mem[slot_ff] <= '{stamp: req_now_us, distance: req_distance};
      end
      if (issue) begin
         rd_ff <= ring_mem[idx_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= WINDOW_RESET;
         slot_ff       <= '0;
         stored_ff     <= '0;
         total_ff      <= '0;
         start_time_ff <= '0;
         last_ff       <= '0;
         running_ff    <= 1'b0;
         query_ff      <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         if (cmd.capture) begin
            query_ff <= (req_operation == OP_QUERY);
            case (req_operation)
               OP_RECORD: begin
                  start_time_ff <= req_now_us;
                  last_ff       <= running_ff ? req_now_us - start_time_ff : '0;
                  running_ff    <= 1'b1;
                  slot_ff       <= slot_in;
                  if (stored_ff < CNT_W'(DEPTH)) begin
                     stored_ff <= stored_ff + 1'b1;
                  end
                  total_ff      <= total_ff + 1'b1;
               end
               OP_RESTART: begin
                  start_time_ff <= req_now_us;
                  last_ff       <= '0;
                  running_ff    <= 1'b1;
               end
               default: begin
               end
            endcase
         end
         if (cmd.calc_start) begin
            rd_valid_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            rd_valid_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff <= req_now_us;
      end
      if (cmd.calc_span) begin
         span_ff <= SPAN_W'(window_ff) * US_PER_MS;
      end
      if (cmd.calc_start) begin
         lower_ff <= lower_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_span) begin
         count_ff <= '0;
         acc_ff   <= '0;
      end else if (cmd.scan_step && rd_valid_ff && hit) begin
         count_ff <= count_ff + 1'b1;
         acc_ff   <= acc_ff + SUM_W'(rd_ff.distance);
      end else if (cmd.div_step) begin
         if (!diff[CNT_W]) begin
            rem_ff <= diff[CNT_W-1:0];
            acc_ff <= {acc_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[CNT_W-1:0];
            acc_ff <= {acc_ff[SUM_W-2:0], 1'b0};
         end
         steps_ff <= steps_ff - 1'b1;
      end
      if (cmd.calc_start) begin
         idx_ff <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.calc_span) begin
         steps_ff <= '0;
      end else if (cmd.div_init) begin
         rem_ff   <= '0;
         steps_ff <= STEP_W'(SUM_W);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_window_count     <= query_ff ? fit_count(count_ff) : '0;
         rsp_average_distance <= (query_ff && (count_ff != '0)) ? acc_ff[DIST_W-1:0] : '0;
         rsp_total_count      <= total_ff;
         rsp_stored_count     <= fit_count(stored_ff);
         rsp_interval_us      <= last_ff;
         rsp_timer_running    <= running_ff;
      end
   end

   a_stored_bounded: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CNT_W'(DEPTH))
      else $error("Stored entry count exceeds the ring depth.");

   a_count_within_scan: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step || cmd.div_init) |-> (count_ff <= idx_ff) && (idx_ff <= stored_ff))
      else $error("Window count or scan index out of step with the stored entries.");

   a_total_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && (req_operation == OP_RECORD)) |=>
         (total_ff == TOTAL_W'($past(total_ff) + 1'b1)))
      else $error("Event total did not advance on a record item.");

   a_first_interval: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && (req_operation == OP_RECORD) && !running_ff) |=>
         (last_ff == '0) && running_ff)
      else $error("First recorded event did not start the interval timer cleanly.");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for windowed_event_statistics_core: a directed table, then random
// record, query, restart and unknown items, checked against an in-bench model or literal table results.
// Depends on wes_pkg and the request and response channel interfaces.
module tb;
   import wes_pkg::*;

   localparam logic [OP_W-1:0]   OP_UNKNOWN       = 2'd3;
   localparam int                LONG_HOLD_CYCLES = 400;
   localparam int                SETTLE_CYCLES    = 120;
   localparam int                PHASE_ITEMS      = 270;
   localparam int                NUM_PHASES       = 7;
   localparam int                NUM_DIRECTED     = 18;
   localparam logic [TIME_W-1:0] TIME_MAX         = '1;
   localparam logic [DIST_W-1:0] DIST_MAX         = '1;

   typedef struct packed {
      logic [OUT_CNT_W-1:0] window_count;
      logic [DIST_W-1:0]    average_distance;
      logic [TOTAL_W-1:0]   total_count;
      logic [OUT_CNT_W-1:0] stored_count;
      logic [TIME_W-1:0]    interval_us;
      logic                 timer_running;
   } stats_result_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [TIME_W-1:0] now_us;
      logic [DIST_W-1:0] distance;
      logic              literal_given;
      stats_result_type  literal;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [WINDOW_W-1:0] csr_write_data = '0;

   wes_req_if req_chan ();
   wes_rsp_if rsp_chan ();

   windowed_event_statistics_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Model state of the block.
   logic [TIME_W-1:0]   ring_time [DEPTH];
   logic [DIST_W-1:0]   ring_dist [DEPTH];
   logic [SLOT_W-1:0]   ring_slot = '0;
   logic [CNT_W-1:0]    ring_fill = '0;
   logic [TOTAL_W-1:0]  event_total = '0;
   logic [TIME_W-1:0]   timer_start = '0;
   logic [TIME_W-1:0]   last_gap = '0;
   logic                timer_on = 1'b0;
   logic [WINDOW_W-1:0] window_ms = WINDOW_RESET;

   stats_result_type pending_results [$];
   int            mismatches = 0;
   int            burst_left = 1;
   logic          long_hold_request = 1'b0;
   logic [TIME_W-1:0] time_base = '0;

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{OP_QUERY,   0,          0,          1'b1, '{0, 0, 0, 0, 0, 0}},
      '{OP_UNKNOWN, TIME_MAX,   DIST_MAX,   1'b1, '{0, 0, 0, 0, 0, 0}},
      '{OP_RECORD,  1000,       DIST_MAX,   1'b1, '{0, 0, 1, 1, 0, 1}},
      '{OP_RECORD,  3500,       0,          1'b1, '{0, 0, 2, 2, 2500, 1}},
      '{OP_QUERY,   3500,       0,          1'b1, '{2, 24'h7FFFFF, 2, 2, 2500, 1}},
      '{OP_QUERY,   2000,       DIST_MAX,   1'b1, '{1, DIST_MAX, 2, 2, 2500, 1}},
      '{OP_RESTART, 10000,      0,          1'b1, '{0, 0, 2, 2, 0, 1}},
      '{OP_RECORD,  9000,       24'h000123, 1'b1, '{0, 0, 3, 3, 48'hFFFF_FFFF_FC18, 1}},
      '{OP_RECORD,  TIME_MAX,   24'h000100, 1'b0, '0},
      '{OP_QUERY,   TIME_MAX,   0,          1'b0, '0},
      '{OP_QUERY,   60_003_500, 0,          1'b0, '0},
      '{OP_QUERY,   60_001_000, 0,          1'b0, '0},
      '{OP_QUERY,   60_001_001, 0,          1'b0, '0},
      '{OP_QUERY,   60_009_000, 0,          1'b0, '0},
      '{OP_RESTART, 0,          DIST_MAX,   1'b0, '0},
      '{OP_UNKNOWN, 1234,       5,          1'b0, '0},
      '{OP_RECORD,  0,          0,          1'b0, '0},
      '{OP_QUERY,   0,          0,          1'b0, '0}
   };

   function automatic stats_result_type compute_statistics(input logic [OP_W-1:0] op,
                                                           input logic [TIME_W-1:0] now,
                                                           input logic [DIST_W-1:0] dist_value);
      stats_result_type res;
      logic [63:0]   span;
      logic [63:0]   start;
      logic [63:0]   sum;
      logic [63:0]   hits;
      res = '0;
      case (op)
         OP_RECORD: begin
            ring_time[ring_slot] = now;
            ring_dist[ring_slot] = dist_value;
            if (!timer_on) begin
               timer_start = now;
               last_gap = '0;
               timer_on = 1'b1;
            end else begin
               last_gap = now - timer_start;
               timer_start = now;
            end
            ring_slot = ring_slot + 1'b1;
            if (int'(ring_fill) < DEPTH) begin
               ring_fill = ring_fill + 1'b1;
            end
            event_total = event_total + 1'b1;
         end
         OP_QUERY: begin
            span = 64'(window_ms) * 64'd1000;
            start = (span > 64'(now)) ? 64'd0 : 64'(now) - span;
            sum = '0;
            hits = '0;
            for (int i = 0; i < int'(ring_fill); i++) begin
               if (64'(ring_time[i]) >= start && ring_time[i] <= now) begin
                  sum = sum + 64'(ring_dist[i]);
                  hits = hits + 1;
               end
            end
            res.window_count = hits[OUT_CNT_W-1:0];
            res.average_distance = (hits != 0) ? DIST_W'(sum / hits) : '0;
         end
         OP_RESTART: begin
            timer_start = now;
            last_gap = '0;
            timer_on = 1'b1;
         end
         default: begin
         end
      endcase
      res.total_count = event_total;
      res.stored_count = ring_fill[OUT_CNT_W-1:0];
      res.interval_us = last_gap;
      res.timer_running = timer_on;
      return res;
   endfunction

   function automatic logic [63:0] rand_below(input logic [63:0] bound);
      return {$urandom, $urandom} % bound;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 200) begin
         $display("mismatch in %s: got %0h, expected %0h, at %0t", what, got, want, $time);
      end
   endtask

   // Called at a falling edge; returns at a falling edge after acceptance, or after a burst-end gap.
   task automatic offer_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                             input logic [DIST_W-1:0] dist_value, input logic literal_given,
                             input stats_result_type literal);
      stats_result_type expected;
      req_chan.operation = op;
      req_chan.now_us = now;
      req_chan.distance = dist_value;
      req_chan.valid = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      expected = compute_statistics(op, now, dist_value);
      if (literal_given) begin
         expected = literal;
      end
      pending_results.push_back(expected);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
   endtask

   task automatic drain_results();
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_window(input logic [WINDOW_W-1:0] value);
      drain_results();
      csr_write_data = value;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      window_ms = value;
   endtask

   task automatic issue_random_item(input logic [63:0] span);
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] now;
      logic [DIST_W-1:0] dist_value;
      int                pick;
      pick = $urandom_range(0, 99);
      dist_value = DIST_W'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         dist_value = ($urandom_range(0, 1) == 1) ? DIST_MAX : '0;
      end
      now = time_base;
      if (pick < 12) begin
         op = OP_W'($urandom_range(0, 3));
         now = TIME_W'({$urandom, $urandom});
      end else if (pick < 62) begin
         op = OP_RECORD;
         time_base = time_base + TIME_W'(rand_below(span / 16 + 2));
         now = time_base;
      end else if (pick < 92) begin
         op = OP_QUERY;
         case ($urandom_range(0, 3))
            0: now = time_base + TIME_W'(rand_below(span / 2 + 2));
            1: now = time_base - TIME_W'(rand_below(span / 8 + 2));
            default: begin
               if (ring_fill != 0) begin
                  now = ring_time[$urandom_range(0, int'(ring_fill) - 1)] + TIME_W'(span)
                        + TIME_W'($urandom_range(0, 1));
               end
            end
         endcase
      end else if (pick < 96) begin
         op = OP_RESTART;
      end else begin
         op = OP_UNKNOWN;
      end
      offer_item(op, now, dist_value, 1'b0, '0);
   endtask

   initial begin : result_receiver
      int hold_left;
      int run_left;
      hold_left = 0;
      run_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (run_left > 0) begin
            rsp_chan.ready = 1'b1;
            run_left--;
         end else begin
            rsp_chan.ready = 1'b0;
            hold_left = $urandom_range(0, 5);
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(1, 12);
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      stats_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_chan.total_count), 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.window_count !== want.window_count)
               report_mismatch("window_count", 64'(rsp_chan.window_count),
                               64'(want.window_count));
            if (rsp_chan.average_distance !== want.average_distance)
               report_mismatch("average_distance", 64'(rsp_chan.average_distance),
                               64'(want.average_distance));
            if (rsp_chan.total_count !== want.total_count)
               report_mismatch("total_count", 64'(rsp_chan.total_count),
                               64'(want.total_count));
            if (rsp_chan.stored_count !== want.stored_count)
               report_mismatch("stored_count", 64'(rsp_chan.stored_count),
                               64'(want.stored_count));
            if (rsp_chan.interval_us !== want.interval_us)
               report_mismatch("interval_us", 64'(rsp_chan.interval_us),
                               64'(want.interval_us));
            if (rsp_chan.timer_running !== want.timer_running)
               report_mismatch("timer_running", 64'(rsp_chan.timer_running),
                               64'(want.timer_running));
         end
      end
   end

   initial begin : stimulus
      logic [WINDOW_W-1:0] phase_window [NUM_PHASES];
      logic [63:0]         span;
      req_chan.valid = 1'b0;
      req_chan.operation = '0;
      req_chan.now_us = '0;
      req_chan.distance = '0;
      phase_window = '{27'd86_400_000, 27'd1, 27'h7FF_FFFF, 27'd0, 27'd0, 27'd0, WINDOW_RESET};
      phase_window[4] = WINDOW_W'($urandom_range(1, 86_400_000));
      phase_window[5] = WINDOW_W'($urandom_range(1, 1000));
      repeat (2) @(negedge clock);
      reset = 1'b0;
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         offer_item(directed_rows[r].operation, directed_rows[r].now_us,
                    directed_rows[r].distance, directed_rows[r].literal_given,
                    directed_rows[r].literal);
      end
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_window(phase_window[p]);
         span = 64'(phase_window[p]) * 64'd1000;
         case ($urandom_range(0, 3))
            0: time_base = TIME_W'({$urandom, $urandom});
            1: time_base = TIME_MAX - TIME_W'(rand_below(span * 2 + 1));
            default: time_base = TIME_W'(rand_below(span / 2 + 1));
         endcase
         // The sender keeps offering items while the receiver holds off, filling the block.
         if (p == 1) begin
            long_hold_request = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            issue_random_item(span);
         end
      end
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
src/wes_pkg.sv
src/wes_channels.sv
src/wes_ctrl.sv
src/wes_datapath.sv
src/windowed_event_statistics_core.sv
tb/tb.sv
